/* rtl/qrs_pkg.sv */
// Shared types, constants and root-count codes of the quadratic root solver.
package qrs_pkg;

    // Default fixed-point format of coefficients and roots.
    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Width of each coefficient or root field on the stream ports.
    localparam int FIELD_W = 32;

    // Root-count codes.
    localparam logic [1:0] COUNT_NONE = 2'd0;
    localparam logic [1:0] COUNT_ONE  = 2'd1;
    localparam logic [1:0] COUNT_TWO  = 2'd2;
    localparam logic [1:0] COUNT_INF  = 2'd3;

    // Case flags carried along the square-root chain.
    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic c_zero;
        logic d_neg;
    } t_sq_flags;

    // Result tag carried along the divider chain.
    typedef struct packed {
        logic [1:0] count;
        logic       neg_p;
        logic       neg_m;
    } t_div_tag;

endpackage

/* rtl/qrs_sqrt_cell.sv */
// One cell of the square-root chain: settles one bit of the integer root.
module qrs_sqrt_cell #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [2*COEF_WIDTH+1:0]      i_rad,
    input  logic [COEF_WIDTH+3:0]        i_rem,
    input  logic [COEF_WIDTH:0]          i_root,
    input  logic signed [COEF_WIDTH-1:0] i_a,
    input  logic signed [COEF_WIDTH-1:0] i_b,
    input  logic signed [COEF_WIDTH-1:0] i_c,
    input  qrs_pkg::t_sq_flags           i_flags,
    output logic                         o_valid,
    output logic [2*COEF_WIDTH+1:0]      o_rad,
    output logic [COEF_WIDTH+3:0]        o_rem,
    output logic [COEF_WIDTH:0]          o_root,
    output logic signed [COEF_WIDTH-1:0] o_a,
    output logic signed [COEF_WIDTH-1:0] o_b,
    output logic signed [COEF_WIDTH-1:0] o_c,
    output qrs_pkg::t_sq_flags           o_flags
);

    localparam int DW = 2 * COEF_WIDTH + 2;
    localparam int RW = COEF_WIDTH + 4;
    localparam int NS = COEF_WIDTH + 1;

    logic [RW-1:0] w_trem;
    logic [RW-1:0] w_trial;
    logic          w_take;

    logic                         r_valid;
    logic [DW-1:0]                r_rad;
    logic [RW-1:0]                r_rem;
    logic [NS-1:0]                r_root;
    logic signed [COEF_WIDTH-1:0] r_a;
    logic signed [COEF_WIDTH-1:0] r_b;
    logic signed [COEF_WIDTH-1:0] r_c;
    qrs_pkg::t_sq_flags           r_flags;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        w_trem  = {i_rem[RW-3:0], i_rad[DW-1 -: 2]};
        w_trial = RW'({i_root, 2'b01});
        w_take  = (w_trem >= w_trial);
    end

    // Valid bit of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Partial remainder, root and the carried coefficients.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad   <= i_rad << 2;
            r_rem   <= w_take ? (w_trem - w_trial) : w_trem;
            r_root  <= {i_root[NS-2:0], w_take};
            r_a     <= i_a;
            r_b     <= i_b;
            r_c     <= i_c;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_c     = r_c;
    assign o_flags = r_flags;

endmodule

/* rtl/qrs_div_cell.sv */
// One cell of the divider chain: settles one quotient bit of both roots.
module qrs_div_cell #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [COEF_WIDTH:0]                 i_den,
    input  logic [COEF_WIDTH+FRAC_BITS+1:0]     i_dvd_p,
    input  logic [COEF_WIDTH+FRAC_BITS+1:0]     i_dvd_m,
    input  logic [COEF_WIDTH:0]                 i_rem_p,
    input  logic [COEF_WIDTH:0]                 i_rem_m,
    input  logic [COEF_WIDTH+FRAC_BITS+1:0]     i_quo_p,
    input  logic [COEF_WIDTH+FRAC_BITS+1:0]     i_quo_m,
    input  qrs_pkg::t_div_tag                   i_tag,
    output logic                                o_valid,
    output logic [COEF_WIDTH:0]                 o_den,
    output logic [COEF_WIDTH+FRAC_BITS+1:0]     o_dvd_p,
    output logic [COEF_WIDTH+FRAC_BITS+1:0]     o_dvd_m,
    output logic [COEF_WIDTH:0]                 o_rem_p,
    output logic [COEF_WIDTH:0]                 o_rem_m,
    output logic [COEF_WIDTH+FRAC_BITS+1:0]     o_quo_p,
    output logic [COEF_WIDTH+FRAC_BITS+1:0]     o_quo_m,
    output qrs_pkg::t_div_tag                   o_tag
);

    localparam int NQ  = COEF_WIDTH + FRAC_BITS + 2;
    localparam int DNW = COEF_WIDTH + 1;

    logic [DNW:0] w_den_x;
    logic [DNW:0] w_t_p;
    logic [DNW:0] w_t_m;
    logic [DNW:0] w_d_p;
    logic [DNW:0] w_d_m;
    logic         w_ge_p;
    logic         w_ge_m;

    logic              r_valid;
    logic [DNW-1:0]    r_den;
    logic [NQ-1:0]     r_dvd_p;
    logic [NQ-1:0]     r_dvd_m;
    logic [DNW-1:0]    r_rem_p;
    logic [DNW-1:0]    r_rem_m;
    logic [NQ-1:0]     r_quo_p;
    logic [NQ-1:0]     r_quo_m;
    qrs_pkg::t_div_tag r_tag;

    // Restoring step on both lanes against the shared divisor.
    always_comb begin
        w_den_x = {1'b0, i_den};
        w_t_p   = {i_rem_p, i_dvd_p[NQ-1]};
        w_t_m   = {i_rem_m, i_dvd_m[NQ-1]};
        w_d_p   = w_t_p - w_den_x;
        w_d_m   = w_t_m - w_den_x;
        w_ge_p  = (w_t_p >= w_den_x);
        w_ge_m  = (w_t_m >= w_den_x);
    end

    // Valid bit of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Remainders, quotients and the carried tag.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_dvd_p <= i_dvd_p << 1;
            r_dvd_m <= i_dvd_m << 1;
            r_rem_p <= w_ge_p ? w_d_p[DNW-1:0] : w_t_p[DNW-1:0];
            r_rem_m <= w_ge_m ? w_d_m[DNW-1:0] : w_t_m[DNW-1:0];
            r_quo_p <= {i_quo_p[NQ-2:0], w_ge_p};
            r_quo_m <= {i_quo_m[NQ-2:0], w_ge_m};
            r_tag   <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_dvd_p = r_dvd_p;
    assign o_dvd_m = r_dvd_m;
    assign o_rem_p = r_rem_p;
    assign o_rem_m = r_rem_m;
    assign o_quo_p = r_quo_p;
    assign o_quo_m = r_quo_m;
    assign o_tag   = r_tag;

endmodule

/* rtl/quadratic_root_solver_core.sv */
// Top level of the quadratic root solver: front stages, cell chains and output register.

// Solves a*x^2+b*x+c=0 over signed fixed-point coefficients and returns the root
// count and both roots, truncated toward zero and saturated with an overflow flag.
// The block takes one request in every cycle and is fully pipelined: a request
// passes the front stages, the chain of COEF_WIDTH+1 square-root cells, one per
// root bit, and the chain of COEF_WIDTH+FRAC_BITS+2 divider cells, one per quotient
// bit (default format Q16.16). When the output is held off the whole pipeline waits
// and input ready drops.
module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // coef_quad [31:0], coef_lin [63:32], coef_free [95:64]
    input  logic [95:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // root_plus [31:0], root_minus [63:32]
    output logic [63:0] o_m_axis_tdata,
    // root_count [1:0], overflow [2]
    output logic [2:0]  o_m_axis_tuser
);

    localparam int W   = COEF_WIDTH;
    localparam int FW  = qrs_pkg::FIELD_W;
    localparam int DW  = 2 * W + 2;
    localparam int RW  = W + 4;
    localparam int NS  = W + 1;
    localparam int NW  = W + 3;
    localparam int DNW = W + 1;
    localparam int NQ  = W + FRAC_BITS + 2;

    logic w_en;

    // Front stage registers.
    logic                r1_valid;
    logic signed [W-1:0] r1_a;
    logic signed [W-1:0] r1_b;
    logic signed [W-1:0] r1_c;

    logic                r2_valid;
    logic signed [W-1:0] r2_a;
    logic signed [W-1:0] r2_b;
    logic signed [W-1:0] r2_c;
    logic [2*W-1:0]      r2_b2;
    logic [2*W-1:0]      r2_ac;
    qrs_pkg::t_sq_flags  r2_flags;

    logic [W-1:0]   w_mag_a;
    logic [W-1:0]   w_mag_b;
    logic [W-1:0]   w_mag_c;
    logic [DW-1:0]  w_b2x;
    logic [DW-1:0]  w_q4;
    logic [DW-1:0]  w_sum;
    logic [DW:0]    w_diff;
    logic           w_ac_pos;
    logic           w_d_neg;
    logic [DW-1:0]  w_disc;

    // Square-root chain links.
    logic                sq_valid [0:NS];
    logic [DW-1:0]       sq_rad   [0:NS];
    logic [RW-1:0]       sq_rem   [0:NS];
    logic [NS-1:0]       sq_root  [0:NS];
    logic signed [W-1:0] sq_a     [0:NS];
    logic signed [W-1:0] sq_b     [0:NS];
    logic signed [W-1:0] sq_c     [0:NS];
    qrs_pkg::t_sq_flags  sq_flags [0:NS];

    logic                r3_valid;
    logic [DW-1:0]       r3_disc;
    logic signed [W-1:0] r3_a;
    logic signed [W-1:0] r3_b;
    logic signed [W-1:0] r3_c;
    qrs_pkg::t_sq_flags  r3_flags;

    // Numerator stage.
    logic signed [NW-1:0]  w_bx;
    logic signed [NW-1:0]  w_sx;
    logic signed [NW-1:0]  w_num_p;
    logic signed [NW-1:0]  w_num_m;
    logic signed [DNW-1:0] w_ax;
    logic signed [DNW-1:0] w_den;
    logic [NW-1:0]         w_abs_p;
    logic [NW-1:0]         w_abs_m;
    logic [DNW-1:0]        w_abs_den;
    logic [1:0]            w_count;
    qrs_pkg::t_sq_flags    w_fl;

    logic              r4_valid;
    logic [DNW-1:0]    r4_den;
    logic [NQ-1:0]     r4_dvd_p;
    logic [NQ-1:0]     r4_dvd_m;
    qrs_pkg::t_div_tag r4_tag;

    // Divider chain links.
    logic              dv_valid [0:NQ];
    logic [DNW-1:0]    dv_den   [0:NQ];
    logic [NQ-1:0]     dv_dvd_p [0:NQ];
    logic [NQ-1:0]     dv_dvd_m [0:NQ];
    logic [DNW-1:0]    dv_rem_p [0:NQ];
    logic [DNW-1:0]    dv_rem_m [0:NQ];
    logic [NQ-1:0]     dv_quo_p [0:NQ];
    logic [NQ-1:0]     dv_quo_m [0:NQ];
    qrs_pkg::t_div_tag dv_tag   [0:NQ];

    // Saturation and output register.
    logic [NQ-1:0]       w_lim;
    logic [NQ-1:0]       w_neg_qp;
    logic [NQ-1:0]       w_neg_qm;
    logic signed [W-1:0] w_root_p;
    logic signed [W-1:0] w_root_m;
    logic                w_ov_p;
    logic                w_ov_m;
    logic                w_has_roots;
    qrs_pkg::t_div_tag   w_tag;

    logic                r_out_valid;
    logic signed [W-1:0] r_out_p;
    logic signed [W-1:0] r_out_m;
    logic [1:0]          r_out_count;
    logic                r_out_ov;

    // The whole pipeline moves unless a finished result is held off.
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Valid bits of the front stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid    <= i_s_axis_tvalid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= sq_valid[NS];
            r_out_valid <= dv_valid[NQ];
        end
    end

    // Capture the request, keeping the low COEF_WIDTH bits of each field.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a <= i_s_axis_tdata[0 +: W];
            r1_b <= i_s_axis_tdata[FW +: W];
            r1_c <= i_s_axis_tdata[2*FW +: W];
        end
    end

    // Magnitudes for the products.
    always_comb begin
        w_mag_a = r1_a[W-1] ? W'(-r1_a) : W'(r1_a);
        w_mag_b = r1_b[W-1] ? W'(-r1_b) : W'(r1_b);
        w_mag_c = r1_c[W-1] ? W'(-r1_c) : W'(r1_c);
    end

    // Products b*b and a*c as magnitudes.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_a            <= r1_a;
            r2_b            <= r1_b;
            r2_c            <= r1_c;
            r2_b2           <= w_mag_b * w_mag_b;
            r2_ac           <= w_mag_a * w_mag_c;
            r2_flags.a_zero <= (r1_a == '0);
            r2_flags.b_zero <= (r1_b == '0);
            r2_flags.c_zero <= (r1_c == '0);
            r2_flags.d_neg  <= 1'b0;
        end
    end

    // Exact discriminant: add or subtract 4ac according to the sign of a*c; zero when a is zero or it is negative.
    always_comb begin
        w_b2x    = DW'(r2_b2);
        w_q4     = {r2_ac, 2'b00};
        w_sum    = w_b2x + w_q4;
        w_diff   = {1'b0, w_b2x} - {1'b0, w_q4};
        w_ac_pos = (r2_a[W-1] == r2_c[W-1]) && !r2_flags.c_zero;
        w_d_neg  = !r2_flags.a_zero && w_ac_pos && w_diff[DW];
        if (r2_flags.a_zero || w_d_neg) begin
            w_disc = '0;
        end else if (w_ac_pos) begin
            w_disc = w_diff[DW-1:0];
        end else begin
            w_disc = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_disc  <= w_disc;
            r3_a     <= r2_a;
            r3_b     <= r2_b;
            r3_c     <= r2_c;
            r3_flags <= '{a_zero: r2_flags.a_zero, b_zero: r2_flags.b_zero,
                          c_zero: r2_flags.c_zero, d_neg: w_d_neg};
        end
    end

    // Square-root chain, one cell per root bit.
    assign sq_valid[0] = r3_valid;
    assign sq_rad[0]   = r3_disc;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_a[0]     = r3_a;
    assign sq_b[0]     = r3_b;
    assign sq_c[0]     = r3_c;
    assign sq_flags[0] = r3_flags;

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        qrs_sqrt_cell #(
            .COEF_WIDTH(COEF_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_valid[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_a     (sq_a[k]),
            .i_b     (sq_b[k]),
            .i_c     (sq_c[k]),
            .i_flags (sq_flags[k]),
            .o_valid (sq_valid[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_a     (sq_a[k+1]),
            .o_b     (sq_b[k+1]),
            .o_c     (sq_c[k+1]),
            .o_flags (sq_flags[k+1])
        );
    end

    // Numerators, divisor and the root count.
    always_comb begin
        w_fl    = sq_flags[NS];
        w_bx    = NW'(sq_b[NS]);
        w_sx    = signed'(NW'(sq_root[NS]));
        w_ax    = DNW'(sq_a[NS]);
        if (w_fl.a_zero) begin
            w_num_p = -NW'(sq_c[NS]);
            w_num_m = -NW'(sq_c[NS]);
            w_den   = DNW'(sq_b[NS]);
        end else begin
            w_num_p = w_sx - w_bx;
            w_num_m = -w_bx - w_sx;
            w_den   = w_ax + w_ax;
        end
        w_abs_p   = w_num_p[NW-1] ? NW'(-w_num_p) : NW'(w_num_p);
        w_abs_m   = w_num_m[NW-1] ? NW'(-w_num_m) : NW'(w_num_m);
        w_abs_den = w_den[DNW-1] ? DNW'(-w_den) : DNW'(w_den);
        if (w_fl.a_zero) begin
            if (w_fl.b_zero) begin
                w_count = w_fl.c_zero ? qrs_pkg::COUNT_INF : qrs_pkg::COUNT_NONE;
            end else begin
                w_count = qrs_pkg::COUNT_ONE;
            end
        end else if (w_fl.d_neg) begin
            w_count = qrs_pkg::COUNT_NONE;
        end else if (sq_root[NS] == '0) begin
            w_count = qrs_pkg::COUNT_ONE;
        end else begin
            w_count = qrs_pkg::COUNT_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_den       <= w_abs_den;
            r4_dvd_p     <= NQ'(w_abs_p[W+1:0]) << FRAC_BITS;
            r4_dvd_m     <= NQ'(w_abs_m[W+1:0]) << FRAC_BITS;
            r4_tag.count <= w_count;
            r4_tag.neg_p <= w_num_p[NW-1] ^ w_den[DNW-1];
            r4_tag.neg_m <= w_num_m[NW-1] ^ w_den[DNW-1];
        end
    end

    // Divider chain, one cell per quotient bit.
    assign dv_valid[0] = r4_valid;
    assign dv_den[0]   = r4_den;
    assign dv_dvd_p[0] = r4_dvd_p;
    assign dv_dvd_m[0] = r4_dvd_m;
    assign dv_rem_p[0] = '0;
    assign dv_rem_m[0] = '0;
    assign dv_quo_p[0] = '0;
    assign dv_quo_m[0] = '0;
    assign dv_tag[0]   = r4_tag;

    for (genvar k = 0; k < NQ; k++) begin : g_div
        qrs_div_cell #(
            .COEF_WIDTH(COEF_WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (dv_valid[k]),
            .i_den   (dv_den[k]),
            .i_dvd_p (dv_dvd_p[k]),
            .i_dvd_m (dv_dvd_m[k]),
            .i_rem_p (dv_rem_p[k]),
            .i_rem_m (dv_rem_m[k]),
            .i_quo_p (dv_quo_p[k]),
            .i_quo_m (dv_quo_m[k]),
            .i_tag   (dv_tag[k]),
            .o_valid (dv_valid[k+1]),
            .o_den   (dv_den[k+1]),
            .o_dvd_p (dv_dvd_p[k+1]),
            .o_dvd_m (dv_dvd_m[k+1]),
            .o_rem_p (dv_rem_p[k+1]),
            .o_rem_m (dv_rem_m[k+1]),
            .o_quo_p (dv_quo_p[k+1]),
            .o_quo_m (dv_quo_m[k+1]),
            .o_tag   (dv_tag[k+1])
        );
    end

    // Apply the signs and saturate to the signed coefficient range.
    always_comb begin
        w_tag       = dv_tag[NQ];
        w_lim       = NQ'(1) << (W - 1);
        w_neg_qp    = -dv_quo_p[NQ];
        w_neg_qm    = -dv_quo_m[NQ];
        w_has_roots = (w_tag.count == qrs_pkg::COUNT_ONE) ||
                      (w_tag.count == qrs_pkg::COUNT_TWO);
        w_ov_p      = 1'b0;
        w_ov_m      = 1'b0;
        if (!w_has_roots) begin
            w_root_p = '0;
        end else if (w_tag.neg_p) begin
            w_ov_p   = (dv_quo_p[NQ] > w_lim);
            w_root_p = w_ov_p ? signed'({1'b1, {(W-1){1'b0}}}) : signed'(w_neg_qp[W-1:0]);
        end else begin
            w_ov_p   = (dv_quo_p[NQ] >= w_lim);
            w_root_p = w_ov_p ? signed'({1'b0, {(W-1){1'b1}}}) : signed'(dv_quo_p[NQ][W-1:0]);
        end
        if (!w_has_roots) begin
            w_root_m = '0;
        end else if (w_tag.neg_m) begin
            w_ov_m   = (dv_quo_m[NQ] > w_lim);
            w_root_m = w_ov_m ? signed'({1'b1, {(W-1){1'b0}}}) : signed'(w_neg_qm[W-1:0]);
        end else begin
            w_ov_m   = (dv_quo_m[NQ] >= w_lim);
            w_root_m = w_ov_m ? signed'({1'b0, {(W-1){1'b1}}}) : signed'(dv_quo_m[NQ][W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_p     <= w_root_p;
            r_out_m     <= w_root_m;
            r_out_count <= w_tag.count;
            r_out_ov    <= w_ov_p || w_ov_m;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {FW'(r_out_m), FW'(r_out_p)};
    assign o_m_axis_tuser  = {r_out_ov, r_out_count};

`ifndef SYNTHESIS
    // No roots or infinitely many roots come with zero roots and no overflow.
    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == qrs_pkg::COUNT_NONE ||
                            o_m_axis_tuser[1:0] == qrs_pkg::COUNT_INF)
        |-> (o_m_axis_tdata == '0) && !o_m_axis_tuser[2])
        else $error("root fields not cleared for a result without roots");

    // A single root is reported in both root fields.
    a_single_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == qrs_pkg::COUNT_ONE)
        |-> (o_m_axis_tdata[FW-1:0] == o_m_axis_tdata[2*FW-1:FW]))
        else $error("single root differs between the two root fields");

    // A held result stays put until it is taken.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while held off");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench of the quadratic root solver core under random stream pressure.
module testbench;

    // Hold-off after the last result, so that the pipeline runs empty.
    localparam int DRAIN_CYCLES = 2 * qrs_pkg::COEF_WIDTH + qrs_pkg::FRAC_BITS + 40;

    typedef struct packed {
        logic [1:0]  count;
        logic [31:0] plus;
        logic [31:0] minus;
        logic        ovf;
    } t_roots;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    // coef_quad [31:0], coef_lin [63:32], coef_free [95:64]
    logic [95:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    // root_plus [31:0], root_minus [63:32]
    logic [63:0] m_data;
    // root_count [1:0], overflow [2]
    logic [2:0]  m_user;

    t_roots roots_due[$];
    int     n_errors = 0;
    int     src_idle_pct = 0;
    int     snk_stall_pct = 0;

    quadratic_root_solver_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always #5 i_clk = ~i_clk;

    // Truncating fixed-point quotient of two wide signed values.
    function automatic logic signed [127:0] fx_quot(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q  = (un << qrs_pkg::FRAC_BITS) / ud;
        return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    endfunction

    // Clamp a root to the signed coefficient range, noting any overflow.
    function automatic logic [31:0] clamp_root(input logic signed [127:0] v, inout logic ovf);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (qrs_pkg::COEF_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            ovf = 1'b1;
            v = hi;
        end else if (v < lo) begin
            ovf = 1'b1;
            v = lo;
        end
        return v[31:0];
    endfunction

    // Expected roots of one coefficient set.
    function automatic t_roots solve_roots(input logic [31:0] qa, lb, fc);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] d;
        logic [127:0]        r;
        logic [127:0]        t;
        t_roots              res;
        a = $signed(qa);
        b = $signed(lb);
        c = $signed(fc);
        res = '0;
        if (a == 0) begin
            if (b == 0) begin
                res.count = (c == 0) ? qrs_pkg::COUNT_INF : qrs_pkg::COUNT_NONE;
            end else begin
                res.count = qrs_pkg::COUNT_ONE;
                res.plus  = clamp_root(fx_quot(-c, b), res.ovf);
                res.minus = res.plus;
            end
        end else begin
            d = b * b - 4 * a * c;
            if (d < 0) begin
                res.count = qrs_pkg::COUNT_NONE;
            end else if (d == 0) begin
                res.count = qrs_pkg::COUNT_ONE;
                res.plus  = clamp_root(fx_quot(-b, 2 * a), res.ovf);
                res.minus = res.plus;
            end else begin
                r = '0;
                for (int k = 33; k >= 0; k--) begin
                    t = r | (128'd1 << k);
                    if (t * t <= d) r = t;
                end
                res.count = qrs_pkg::COUNT_TWO;
                res.plus  = clamp_root(fx_quot(-b + $signed(r), 2 * a), res.ovf);
                res.minus = clamp_root(fx_quot(-b - $signed(r), 2 * a), res.ovf);
            end
        end
        return res;
    endfunction

    // Offer one request, with random idle cycles first, and record its roots once taken.
    task automatic send_coefs(input logic [31:0] qa, lb, fc);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {fc, lb, qa};
        do @(posedge i_clk); while (!s_ready);
        roots_due.push_back(solve_roots(qa, lb, fc));
    endtask

    // Lower valid and wait until every result has come out, then let the pipe settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (roots_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver stalls.
    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n && m_valid && m_ready) begin
            if (roots_due.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%h", $time, m_data, m_user);
                n_errors++;
            end else begin
                want = roots_due.pop_front();
                if (m_user[1:0] !== want.count) begin
                    $display("%0t: root_count expected %0d actual %0d",
                             $time, want.count, m_user[1:0]);
                    n_errors++;
                end
                if (m_data[31:0] !== want.plus) begin
                    $display("%0t: root_plus expected %h actual %h",
                             $time, want.plus, m_data[31:0]);
                    n_errors++;
                end
                if (m_data[63:32] !== want.minus) begin
                    $display("%0t: root_minus expected %h actual %h",
                             $time, want.minus, m_data[63:32]);
                    n_errors++;
                end
                if (m_user[2] !== want.ovf) begin
                    $display("%0t: overflow expected %0d actual %0d",
                             $time, want.ovf, m_user[2]);
                    n_errors++;
                end
            end
        end
    end

    // Extremes and every root-count case.
    task automatic test_directed();
        send_coefs(32'h0, 32'h0, 32'h0);
        send_coefs(32'h0, 32'h0, 32'h0001_0000);
        send_coefs(32'h0, 32'h0, 32'h8000_0000);
        send_coefs(32'h0, 32'h0002_0000, 32'hFFFC_0000);
        send_coefs(32'h0, 32'h0000_0001, 32'h7FFF_FFFF);
        send_coefs(32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
        send_coefs(32'h0, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
        send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_coefs(32'h0001_0000, 32'h0, 32'h0001_0000);
        send_coefs(32'h0001_0000, 32'h0, 32'hFFFF_0000);
        send_coefs(32'h0000_0001, 32'h7FFF_FFFF, 32'h0);
        send_coefs(32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_coefs(32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
        send_coefs(32'h0000_0001, 32'h0, 32'hFFFF_FFFF);
        send_coefs(32'hFFFF_0000, 32'h0, 32'h0);
        send_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();
    endtask

    // Random requests weighted towards each case of interest.
    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        logic [31:0] qa;
        logic [31:0] lb;
        logic [31:0] fc;
        int          m;
        int          k;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            qa = $urandom;
            lb = $urandom;
            fc = $urandom;
            case ($urandom_range(5))
                0: qa = 32'h0;
                1: begin
                    qa = 32'h0;
                    lb = ($urandom_range(3) == 0) ? 32'h0 : lb;
                    fc = ($urandom_range(1) == 0) ? 32'h0 : fc;
                end
                2: begin
                    // Perfect square: b*b equals 4ac.
                    m  = $urandom_range(1, 1000) * ($urandom_range(1) ? 1 : -1);
                    k  = $signed($urandom_range(2000)) - 1000;
                    qa = m * m;
                    lb = 2 * m * k;
                    fc = k * k;
                end
                3: begin
                    qa = $signed(qa) >>> $urandom_range(31);
                    lb = $signed(lb) >>> $urandom_range(31);
                    fc = $signed(fc) >>> $urandom_range(31);
                end
                default: ;
            endcase
            send_coefs(qa, lb, fc);
        end
        drain_results();
    endtask

    // Stimulus sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(450, 0, 0);
        test_random(400, 70, 0);
        test_random(400, 0, 70);
        test_random(450, 38, 38);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
